@@ rtl/linear_probe_hash_table_assert.svh @@
// ----------------------------------------------------------------------------
// Linear probe hash table assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LPHT_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHT_ASSERT(name, prop, msg)
`define LPHT_ASSERT_RST(name, prop, msg)
`endif
`endif

@@ rtl/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared constants, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned DEF_SLOTS      = 1024;
  localparam int unsigned DEF_KEY_BITS   = 64;
  localparam int unsigned DEF_VALUE_BITS = 32;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_LOOKUP = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_COUNT  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_LOCKED = 2'd2;

  localparam logic CFG_ALLOW_DUPS = 1'b0;
  localparam logic CFG_WRITE_LOCK = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_INS_RD,
    ST_INS_EV,
    ST_FIND_RD,
    ST_FIND_EV,
    ST_CNT_RD,
    ST_CNT_EV,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_RE_RD,
    ST_RE_EV,
    ST_DONE
  } state_t;

endpackage

@@ rtl/lpht_slot_ram.sv @@
// ----------------------------------------------------------------------------
// Slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_slot_ram #(
  parameter int unsigned DEPTH = lpht_pkg::DEF_SLOTS,
  parameter int unsigned WIDTH = 1 + lpht_pkg::DEF_KEY_BITS + lpht_pkg::DEF_VALUE_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing table with linear probing, one operation per item.
// ----------------------------------------------------------------------------
// Items enter on the s_ channel: tuser holds the operation, tdata the key
// and value. Each item gives one result item on the m_ channel. The
// configuration registers are written on the cfg channel, which is always
// ready.
// The table is a single-port-write, registered-read memory walked by one
// sequencer; every probe of a slot is a read state, then a compare state.
// A lookup or insert probes on from its home slot; its result is loaded
// into the output register from the done state, and the next item is then
// taken in the idle state. Remove empties the found slot, then reads each
// following entry up to a free slot, empties it and re-inserts it.
// Clear empties every slot in turn. The block takes one item at a time.
// After reset a clearing pass over every slot runs before the first item
// is accepted. A result waits in the output register while the receiver
// stalls; the next item may be accepted meanwhile but its result waits.
// SLOTS must be a power of two.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table #(
  parameter int unsigned SLOTS      = lpht_pkg::DEF_SLOTS,
  parameter int unsigned KEY_BITS   = lpht_pkg::DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = lpht_pkg::DEF_VALUE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // key[63:0], value[95:64]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], found[2], slot_index[12:3], found_value[44:13], match_count[55:45]
  output logic [55:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned WORD_W = 1 + KEY_BITS + VALUE_BITS;

  lpht_pkg::state_t state, state_next;

  logic                  allow_dups, write_lock;
  logic [2:0]            kind, kind_next;
  logic [KEY_BITS-1:0]   key, key_next, mkey, mkey_next;
  logic [VALUE_BITS-1:0] val, val_next, mval, mval_next;
  logic [IDX_W-1:0]      ptr, ptr_next, scan, scan_next;
  logic [CNT_W-1:0]      probe_i, probe_i_next, scan_i, scan_i_next;
  logic [1:0]            res_status, res_status_next;
  logic                  res_found, res_found_next;
  logic [IDX_W-1:0]      res_slot, res_slot_next;
  logic [VALUE_BITS-1:0] res_fval, res_fval_next;
  logic [CNT_W-1:0]      res_count, res_count_next;
  logic                  load_out;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  logic [WORD_W-1:0]     mem_wdata, mem_rdata;

  logic                  rd_valid;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [VALUE_BITS+31:0] in_val_ext;
  logic [IDX_W+9:0]      slot_ext;
  logic [VALUE_BITS+31:0] fval_ext;
  logic [CNT_W+10:0]     count_ext;

  lpht_slot_ram #(
    .DEPTH(SLOTS),
    .WIDTH(WORD_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_valid   = mem_rdata[WORD_W-1];
  assign rd_key     = mem_rdata[VALUE_BITS +: KEY_BITS];
  assign rd_val     = mem_rdata[VALUE_BITS-1:0];
  assign in_val_ext = {{VALUE_BITS{1'b0}}, s_tdata[95:64]};
  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == lpht_pkg::ST_IDLE);
  assign mem_raddr  = (state == lpht_pkg::ST_CNT_RD || state == lpht_pkg::ST_SCAN_RD) ?
                      scan : ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_dups <= 1'b0;
      write_lock <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == lpht_pkg::CFG_ALLOW_DUPS) begin
        allow_dups <= cfg_data;
      end else begin
        write_lock <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpht_pkg::ST_INIT;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
    kind       <= kind_next;
    key        <= key_next;
    val        <= val_next;
    mkey       <= mkey_next;
    mval       <= mval_next;
    scan       <= scan_next;
    probe_i    <= probe_i_next;
    scan_i     <= scan_i_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_slot   <= res_slot_next;
    res_fval   <= res_fval_next;
    res_count  <= res_count_next;
  end

  always_comb begin
    state_next      = state;
    kind_next       = kind;
    key_next        = key;
    val_next        = val;
    mkey_next       = mkey;
    mval_next       = mval;
    ptr_next        = ptr;
    scan_next       = scan;
    probe_i_next    = probe_i;
    scan_i_next     = scan_i;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_slot_next   = res_slot;
    res_fval_next   = res_fval;
    res_count_next  = res_count;
    mem_we          = 1'b0;
    mem_waddr       = ptr;
    mem_wdata       = '0;
    load_out        = 1'b0;
    case (state)
      lpht_pkg::ST_INIT, lpht_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        ptr_next = ptr + 1'b1;
        if (ptr == IDX_W'(SLOTS - 1)) begin
          state_next = (state == lpht_pkg::ST_INIT) ? lpht_pkg::ST_IDLE :
                       lpht_pkg::ST_DONE;
        end
      end
      lpht_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          kind_next       = s_tuser;
          key_next        = s_tdata[KEY_BITS-1:0];
          val_next        = in_val_ext[VALUE_BITS-1:0];
          ptr_next        = s_tdata[IDX_W-1:0];
          probe_i_next    = '0;
          res_status_next = lpht_pkg::STATUS_OK;
          res_found_next  = 1'b0;
          res_slot_next   = '0;
          res_fval_next   = '0;
          res_count_next  = '0;
          case (s_tuser)
            lpht_pkg::KIND_INSERT: begin
              if (write_lock) begin
                res_status_next = lpht_pkg::STATUS_LOCKED;
                state_next      = lpht_pkg::ST_DONE;
              end else begin
                state_next = lpht_pkg::ST_INS_RD;
              end
            end
            lpht_pkg::KIND_LOOKUP, lpht_pkg::KIND_REMOVE, lpht_pkg::KIND_COUNT: begin
              state_next = lpht_pkg::ST_FIND_RD;
            end
            lpht_pkg::KIND_CLEAR: begin
              ptr_next   = '0;
              state_next = lpht_pkg::ST_CLEAR;
            end
            default: begin
              state_next = lpht_pkg::ST_DONE;
            end
          endcase
        end
      end
      lpht_pkg::ST_INS_RD: state_next = lpht_pkg::ST_INS_EV;
      lpht_pkg::ST_INS_EV: begin
        if (!rd_valid || (rd_key == key && !allow_dups)) begin
          mem_we         = 1'b1;
          mem_wdata      = {1'b1, key, val};
          res_found_next = 1'b1;
          res_slot_next  = ptr;
          state_next     = lpht_pkg::ST_DONE;
        end else if (probe_i == CNT_W'(SLOTS - 1)) begin
          res_status_next = lpht_pkg::STATUS_FULL;
          state_next      = lpht_pkg::ST_DONE;
        end else begin
          ptr_next     = ptr + 1'b1;
          probe_i_next = probe_i + 1'b1;
          state_next   = lpht_pkg::ST_INS_RD;
        end
      end
      lpht_pkg::ST_FIND_RD: state_next = lpht_pkg::ST_FIND_EV;
      lpht_pkg::ST_FIND_EV: begin
        if (!rd_valid) begin
          state_next = lpht_pkg::ST_DONE;
        end else if (rd_key == key) begin
          res_found_next = 1'b1;
          res_slot_next  = ptr;
          scan_next      = ptr + 1'b1;
          scan_i_next    = CNT_W'(1);
          state_next     = lpht_pkg::ST_DONE;
          case (kind)
            lpht_pkg::KIND_LOOKUP: res_fval_next = rd_val;
            lpht_pkg::KIND_REMOVE: begin
              if (write_lock) begin
                res_status_next = lpht_pkg::STATUS_LOCKED;
                res_found_next  = 1'b0;
                res_slot_next   = '0;
              end else begin
                mem_we     = 1'b1;
                state_next = lpht_pkg::ST_SCAN_RD;
              end
            end
            lpht_pkg::KIND_COUNT: begin
              res_count_next = CNT_W'(1);
              if (allow_dups) begin
                state_next = lpht_pkg::ST_CNT_RD;
              end
            end
            default: state_next = lpht_pkg::ST_DONE;
          endcase
        end else if (probe_i == CNT_W'(SLOTS - 1)) begin
          state_next = lpht_pkg::ST_DONE;
        end else begin
          ptr_next     = ptr + 1'b1;
          probe_i_next = probe_i + 1'b1;
          state_next   = lpht_pkg::ST_FIND_RD;
        end
      end
      lpht_pkg::ST_CNT_RD: state_next = lpht_pkg::ST_CNT_EV;
      lpht_pkg::ST_CNT_EV: begin
        if (!rd_valid) begin
          state_next = lpht_pkg::ST_DONE;
        end else begin
          if (rd_key == key) begin
            res_count_next = res_count + 1'b1;
          end
          if (scan_i == CNT_W'(SLOTS - 1)) begin
            state_next = lpht_pkg::ST_DONE;
          end else begin
            scan_next   = scan + 1'b1;
            scan_i_next = scan_i + 1'b1;
            state_next  = lpht_pkg::ST_CNT_RD;
          end
        end
      end
      lpht_pkg::ST_SCAN_RD: state_next = lpht_pkg::ST_SCAN_EV;
      lpht_pkg::ST_SCAN_EV: begin
        if (!rd_valid) begin
          state_next = lpht_pkg::ST_DONE;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = scan;
          mkey_next  = rd_key;
          mval_next  = rd_val;
          ptr_next   = rd_key[IDX_W-1:0];
          state_next = lpht_pkg::ST_RE_RD;
        end
      end
      lpht_pkg::ST_RE_RD: state_next = lpht_pkg::ST_RE_EV;
      lpht_pkg::ST_RE_EV: begin
        if (!rd_valid || (rd_key == mkey && !allow_dups)) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, mkey, mval};
          if (scan_i == CNT_W'(SLOTS - 1)) begin
            state_next = lpht_pkg::ST_DONE;
          end else begin
            scan_next   = scan + 1'b1;
            scan_i_next = scan_i + 1'b1;
            state_next  = lpht_pkg::ST_SCAN_RD;
          end
        end else begin
          ptr_next   = ptr + 1'b1;
          state_next = lpht_pkg::ST_RE_RD;
        end
      end
      lpht_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = lpht_pkg::ST_IDLE;
        end
      end
      default: state_next = lpht_pkg::ST_IDLE;
    endcase
  end

  assign slot_ext  = {10'd0, res_slot};
  assign fval_ext  = {32'd0, res_fval};
  assign count_ext = {11'd0, res_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (load_out) begin
      m_tdata <= {count_ext[10:0], fval_ext[31:0], slot_ext[9:0], res_found, res_status};
    end
  end

  `LPHT_ASSERT(a_accept_busy, s_tvalid && s_tready |=> state != lpht_pkg::ST_IDLE,
    "Accepted item did not start the sequencer.")
  `LPHT_ASSERT(a_done_waits,
    state == lpht_pkg::ST_DONE && m_tvalid && !m_tready |=> state == lpht_pkg::ST_DONE,
    "Result overwrote an item not yet taken.")
  `LPHT_ASSERT(a_idle_no_write, state == lpht_pkg::ST_IDLE |-> !mem_we,
    "Slot memory written while idle.")
  `LPHT_ASSERT(a_full_not_found,
    m_tvalid |-> !(m_tdata[1:0] == lpht_pkg::STATUS_FULL && m_tdata[2]),
    "Full status reported with a found key.")
  `LPHT_ASSERT_RST(a_reset_init, rst |=> state == lpht_pkg::ST_INIT && !m_tvalid,
    "Reset did not start the clearing pass.")

endmodule
